>>> src/sqoct_pkg.sv
// sqoct_pkg: shared widths, register map and stage types of the squoct lattice distance block.
// Used by every module under src; depends on nothing.
package sqoct_pkg;

    localparam int COORD_BITS = 10;
    localparam int SIZE_BITS  = 10;
    localparam int DIST_BITS  = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
    localparam int VIRT_BITS  = DIST_BITS - 1;
    localparam int OUT_BITS   = 11;
    localparam int ADDR_BITS  = 4;
    localparam int DATA_BITS  = 32;

    // remainder pipeline: one bit of the restoring remainder per step
    localparam int REM_STAGES          = 3;
    localparam int REM_STEPS_PER_STAGE = (VIRT_BITS + REM_STAGES - 1) / REM_STAGES;

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(96);

    typedef enum logic [1:0] {
        REG_LATTICE_KIND,
        REG_SYNDROME_KIND,
        REG_LATTICE_WIDTH,
        REG_LATTICE_HEIGHT
    } t_reg_idx;

    typedef logic [DIST_BITS-1:0] t_coord;
    typedef logic [VIRT_BITS-1:0] t_vrt;

    typedef struct packed {
        logic                 lattice_kind;
        logic                 syndrome_kind;
        logic [SIZE_BITS-1:0] lattice_width;
        logic [SIZE_BITS-1:0] lattice_height;
    } t_cfg;

    // one endpoint after neighbour selection; rem/dvs feed the (v+1) mod size unit
    typedef struct packed {
        logic   sq;
        logic   along_x;
        t_coord x;
        t_coord y;
        t_coord down;
        t_vrt   rem;
        t_vrt   dvs;
        logic   dvs_zero;
    } t_end;

    typedef struct packed {
        logic   valid;
        logic   same;
        t_end   a;
        t_end   b;
        t_coord sx;
        t_coord sy;
    } t_job;

endpackage

>>> src/sqoct_cfg.sv
// sqoct_cfg: APB-style register file holding lattice kind, syndrome kind and sizes.
// Depends on sqoct_pkg.
module sqoct_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [sqoct_pkg::ADDR_BITS-1:0] i_paddr,
    input  logic [sqoct_pkg::DATA_BITS-1:0] i_pwdata,
    output logic [sqoct_pkg::DATA_BITS-1:0] o_prdata,
    output logic                           o_pready,
    output sqoct_pkg::t_cfg                o_cfg
);

    sqoct_pkg::t_cfg     r_cfg;
    sqoct_pkg::t_reg_idx w_idx;
    logic                w_wr;

    assign w_idx    = sqoct_pkg::t_reg_idx'(i_paddr[sqoct_pkg::ADDR_BITS-1:2]);
    assign w_wr     = i_psel & i_penable & i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lattice_kind   <= 1'b0;
            r_cfg.syndrome_kind  <= 1'b0;
            r_cfg.lattice_width  <= sqoct_pkg::SIZE_RESET;
            r_cfg.lattice_height <= sqoct_pkg::SIZE_RESET;
        end else if (w_wr) begin
            case (w_idx)
                sqoct_pkg::REG_LATTICE_KIND:   r_cfg.lattice_kind  <= i_pwdata[0];
                sqoct_pkg::REG_SYNDROME_KIND:  r_cfg.syndrome_kind <= i_pwdata[0];
                sqoct_pkg::REG_LATTICE_WIDTH:
                    r_cfg.lattice_width  <= i_pwdata[sqoct_pkg::SIZE_BITS-1:0];
                sqoct_pkg::REG_LATTICE_HEIGHT:
                    r_cfg.lattice_height <= i_pwdata[sqoct_pkg::SIZE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_prdata = '0;
        case (w_idx)
            sqoct_pkg::REG_LATTICE_KIND:   o_prdata[0] = r_cfg.lattice_kind;
            sqoct_pkg::REG_SYNDROME_KIND:  o_prdata[0] = r_cfg.syndrome_kind;
            sqoct_pkg::REG_LATTICE_WIDTH:
                o_prdata[sqoct_pkg::SIZE_BITS-1:0] = r_cfg.lattice_width;
            sqoct_pkg::REG_LATTICE_HEIGHT:
                o_prdata[sqoct_pkg::SIZE_BITS-1:0] = r_cfg.lattice_height;
            default: o_prdata = '0;
        endcase
    end

endmodule

>>> src/sqoct_prep.sv
// sqoct_prep: first two pipeline stages - map squoct points to the virtual lattice
// (divide by 3), then pick square-site neighbours. Depends on sqoct_pkg.
module sqoct_prep (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sqoct_pkg::t_cfg                  i_cfg,
    input  logic                             i_valid,
    input  logic [sqoct_pkg::COORD_BITS-1:0] i_first_x,
    input  logic [sqoct_pkg::COORD_BITS-1:0] i_first_y,
    input  logic [sqoct_pkg::COORD_BITS-1:0] i_second_x,
    input  logic [sqoct_pkg::COORD_BITS-1:0] i_second_y,
    output sqoct_pkg::t_job                  o_job
);

    localparam int DB = sqoct_pkg::DIST_BITS;
    localparam logic [DB-1:0] DIV3_MUL = DB'(((1 << (DB + 1)) + 2) / 3);

    typedef struct packed {
        logic              valid;
        logic              same;
        sqoct_pkg::t_coord ax;
        sqoct_pkg::t_coord ay;
        sqoct_pkg::t_coord bx;
        sqoct_pkg::t_coord by;
        sqoct_pkg::t_coord sx;
        sqoct_pkg::t_coord sy;
    } t_pts;

    // floor(n/3) by reciprocal multiply, exact for every n below 2**DB
    function automatic sqoct_pkg::t_coord div3(input sqoct_pkg::t_coord n);
        logic [2*DB-1:0] prod;
        prod = {{DB{1'b0}}, n} * {{DB{1'b0}}, DIV3_MUL};
        return sqoct_pkg::t_coord'(prod >> (DB + 1));
    endfunction

    function automatic sqoct_pkg::t_coord to_virtual(input sqoct_pkg::t_coord c);
        return (c == '0) ? '0 : div3(c - DB'(1));
    endfunction

    function automatic sqoct_pkg::t_end make_end(
        input sqoct_pkg::t_coord x,
        input sqoct_pkg::t_coord y,
        input sqoct_pkg::t_coord sx,
        input sqoct_pkg::t_coord sy,
        input logic              toric,
        input logic              synd
    );
        sqoct_pkg::t_end   e;
        sqoct_pkg::t_coord v;
        sqoct_pkg::t_coord s;
        e.sq      = !toric && (x[0] != y[0]);
        e.along_x = x[0] ^ synd;
        e.x       = x;
        e.y       = y;
        v         = e.along_x ? x : y;
        s         = e.along_x ? sx : sy;
        e.rem      = sqoct_pkg::t_vrt'(v) + sqoct_pkg::VIRT_BITS'(1);
        e.dvs      = sqoct_pkg::t_vrt'(s);
        e.dvs_zero = (s == '0);
        if (v != '0) begin
            e.down = v - DB'(1);
        end else begin
            e.down = (s == '0) ? '0 : s - DB'(1);
        end
        return e;
    endfunction

    t_pts            r_pts, n_pts;
    sqoct_pkg::t_job r_job, n_job;

    always_comb begin
        n_pts.valid = i_valid;
        n_pts.same  = !i_cfg.lattice_kind && (i_first_x == i_second_x)
                      && (i_first_y == i_second_y);
        if (i_cfg.lattice_kind) begin
            n_pts.ax = DB'(i_first_x);
            n_pts.ay = DB'(i_first_y);
            n_pts.bx = DB'(i_second_x);
            n_pts.by = DB'(i_second_y);
            n_pts.sx = DB'(i_cfg.lattice_width);
            n_pts.sy = DB'(i_cfg.lattice_height);
        end else begin
            n_pts.ax = to_virtual(DB'(i_first_x));
            n_pts.ay = to_virtual(DB'(i_first_y));
            n_pts.bx = to_virtual(DB'(i_second_x));
            n_pts.by = to_virtual(DB'(i_second_y));
            n_pts.sx = div3(DB'(i_cfg.lattice_width));
            n_pts.sy = div3(DB'(i_cfg.lattice_height));
        end
    end

    always_comb begin
        n_job.valid = r_pts.valid;
        n_job.same  = r_pts.same;
        n_job.sx    = r_pts.sx;
        n_job.sy    = r_pts.sy;
        n_job.a     = make_end(r_pts.ax, r_pts.ay, r_pts.sx, r_pts.sy,
                               i_cfg.lattice_kind, i_cfg.syndrome_kind);
        n_job.b     = make_end(r_pts.bx, r_pts.by, r_pts.sx, r_pts.sy,
                               i_cfg.lattice_kind, i_cfg.syndrome_kind);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pts.valid <= 1'b0;
            r_job.valid <= 1'b0;
        end else begin
            r_pts <= n_pts;
            r_job <= n_job;
        end
    end

    assign o_job = r_job;

endmodule

>>> src/sqoct_wrap.sv
// sqoct_wrap: pipelined restoring remainder giving (v+1) mod size for both endpoints,
// a few quotient bits per stage. Depends on sqoct_pkg.
module sqoct_wrap (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sqoct_pkg::t_job i_job,
    output sqoct_pkg::t_job o_job
);

    localparam int VB  = sqoct_pkg::VIRT_BITS;
    localparam int SPS = sqoct_pkg::REM_STEPS_PER_STAGE;

    function automatic sqoct_pkg::t_end rem_steps(input sqoct_pkg::t_end e, input int st);
        sqoct_pkg::t_end r;
        logic [2*VB-1:0] acc;
        logic [2*VB-1:0] sub;
        int              bit_i;
        r = e;
        for (int k = 0; k < SPS; k++) begin
            bit_i = VB - 1 - (st * SPS + k);
            if (bit_i >= 0) begin
                acc = {{VB{1'b0}}, r.rem};
                sub = {{VB{1'b0}}, r.dvs} << bit_i;
                if (acc >= sub) begin
                    r.rem = VB'(acc - sub);
                end
            end
        end
        return r;
    endfunction

    sqoct_pkg::t_job w_in    [sqoct_pkg::REM_STAGES];
    sqoct_pkg::t_job n_stage [sqoct_pkg::REM_STAGES];
    sqoct_pkg::t_job r_stage [sqoct_pkg::REM_STAGES];

    for (genvar s = 0; s < sqoct_pkg::REM_STAGES; s++) begin : g_stage
        if (s == 0) begin : g_head
            assign w_in[s] = i_job;
        end else begin : g_tail
            assign w_in[s] = r_stage[s-1];
        end

        always_comb begin
            n_stage[s]   = w_in[s];
            n_stage[s].a = rem_steps(w_in[s].a, s);
            n_stage[s].b = rem_steps(w_in[s].b, s);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stage[s].valid <= 1'b0;
            end else begin
                r_stage[s] <= n_stage[s];
            end
        end
    end

    assign o_job = r_stage[sqoct_pkg::REM_STAGES-1];

endmodule

>>> src/sqoct_dist.sv
// sqoct_dist: per-axis periodic distances for all neighbour pairs, sums, minimum and
// square-endpoint correction, three register stages. Depends on sqoct_pkg.
module sqoct_dist (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sqoct_pkg::t_job                i_job,
    output logic                           o_valid,
    output logic [sqoct_pkg::OUT_BITS-1:0] o_distance
);

    localparam int DB = sqoct_pkg::DIST_BITS;

    typedef struct packed {
        sqoct_pkg::t_coord x;
        sqoct_pkg::t_coord y;
    } t_pt;

    typedef logic [DB:0] t_sum;

    function automatic sqoct_pkg::t_coord axis_dist(
        input sqoct_pkg::t_coord a,
        input sqoct_pkg::t_coord b,
        input sqoct_pkg::t_coord s
    );
        sqoct_pkg::t_coord d;
        d = (a > b) ? a - b : b - a;
        if (d <= s && (s - d) < d) begin
            return s - d;
        end
        return d;
    endfunction

    // up neighbour for up=1, down neighbour otherwise; an octagon stands for itself
    function automatic t_pt cand(input sqoct_pkg::t_end e, input logic up);
        t_pt               p;
        sqoct_pkg::t_coord nv;
        nv  = up ? (e.dvs_zero ? '0 : DB'(e.rem)) : e.down;
        p.x = e.x;
        p.y = e.y;
        if (e.sq) begin
            if (e.along_x) begin
                p.x = nv;
            end else begin
                p.y = nv;
            end
        end
        return p;
    endfunction

    // stage C: axis distances of the four pairs
    logic              r_c_valid, n_c_valid;
    logic              r_c_same,  n_c_same;
    logic [1:0]        r_c_extra, n_c_extra;
    sqoct_pkg::t_coord r_c_dx [4];
    sqoct_pkg::t_coord r_c_dy [4];
    sqoct_pkg::t_coord n_c_dx [4];
    sqoct_pkg::t_coord n_c_dy [4];
    t_pt               w_pa   [2];
    t_pt               w_pb   [2];

    always_comb begin
        w_pa[0]   = cand(i_job.a, 1'b1);
        w_pa[1]   = cand(i_job.a, 1'b0);
        w_pb[0]   = cand(i_job.b, 1'b1);
        w_pb[1]   = cand(i_job.b, 1'b0);
        n_c_valid = i_job.valid;
        n_c_same  = i_job.same;
        n_c_extra = {1'b0, i_job.a.sq} + {1'b0, i_job.b.sq};
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                n_c_dx[i*2+j] = axis_dist(w_pa[i].x, w_pb[j].x, i_job.sx);
                n_c_dy[i*2+j] = axis_dist(w_pa[i].y, w_pb[j].y, i_job.sy);
            end
        end
    end

    // stage D: Manhattan sums, pairwise minimum
    logic       r_d_valid, n_d_valid;
    logic       r_d_same,  n_d_same;
    logic [1:0] r_d_extra, n_d_extra;
    t_sum       r_d_m01, n_d_m01;
    t_sum       r_d_m23, n_d_m23;
    t_sum       w_sum [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_sum[k] = {1'b0, r_c_dx[k]} + {1'b0, r_c_dy[k]};
        end
        n_d_valid = r_c_valid;
        n_d_same  = r_c_same;
        n_d_extra = r_c_extra;
        n_d_m01   = (w_sum[1] < w_sum[0]) ? w_sum[1] : w_sum[0];
        n_d_m23   = (w_sum[3] < w_sum[2]) ? w_sum[3] : w_sum[2];
    end

    // stage E: final minimum plus one per square endpoint
    logic                           r_e_valid, n_e_valid;
    logic [sqoct_pkg::OUT_BITS-1:0] r_e_dist,  n_e_dist;
    t_sum                           w_best;
    logic [DB+1:0]                  w_total;

    always_comb begin
        w_best    = (r_d_m23 < r_d_m01) ? r_d_m23 : r_d_m01;
        w_total   = {1'b0, w_best} + (DB + 2)'(r_d_extra);
        n_e_valid = r_d_valid;
        n_e_dist  = r_d_same ? '0 : sqoct_pkg::OUT_BITS'(w_total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            r_c_valid <= n_c_valid;
            r_d_valid <= n_d_valid;
            r_e_valid <= n_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_same  <= n_c_same;
        r_c_extra <= n_c_extra;
        r_c_dx    <= n_c_dx;
        r_c_dy    <= n_c_dy;
        r_d_same  <= n_d_same;
        r_d_extra <= n_d_extra;
        r_d_m01   <= n_d_m01;
        r_d_m23   <= n_d_m23;
        r_e_dist  <= n_e_dist;
    end

    assign o_valid    = r_e_valid;
    assign o_distance = r_e_dist;

endmodule

>>> src/squoct_lattice_distance.sv
// squoct_lattice_distance: toric / squoct wrap-around lattice distance, 8-stage pipeline.
// Throughput: one start beat every cycle; busy stays low.
// Pipeline order from start to o_valid: divide-by-3, neighbour select,
// 3-stage remainder, pair distances, sums, minimum.
// Reset (synchronous, i_rst_n low) empties the pipeline and restores the registers.
// Depends on sqoct_pkg, sqoct_cfg, sqoct_prep, sqoct_wrap, sqoct_dist.
module squoct_lattice_distance (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sqoct_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [sqoct_pkg::DATA_BITS-1:0]  pwdata,
    output logic [sqoct_pkg::DATA_BITS-1:0]  prdata,
    output logic                             pready,
    input  logic                             start,
    output logic                             busy,
    input  logic [sqoct_pkg::COORD_BITS-1:0] i_first_x,
    input  logic [sqoct_pkg::COORD_BITS-1:0] i_first_y,
    input  logic [sqoct_pkg::COORD_BITS-1:0] i_second_x,
    input  logic [sqoct_pkg::COORD_BITS-1:0] i_second_y,
    output logic                             o_valid,
    output logic [sqoct_pkg::OUT_BITS-1:0]   o_distance
);

    sqoct_pkg::t_cfg w_cfg;
    sqoct_pkg::t_job w_prep_job;
    sqoct_pkg::t_job w_wrap_job;

    assign busy = 1'b0;

    sqoct_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    sqoct_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (start),
        .i_first_x  (i_first_x),
        .i_first_y  (i_first_y),
        .i_second_x (i_second_x),
        .i_second_y (i_second_y),
        .o_job      (w_prep_job)
    );

    sqoct_wrap u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_prep_job),
        .o_job   (w_wrap_job)
    );

    sqoct_dist u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (w_wrap_job),
        .o_valid    (o_valid),
        .o_distance (o_distance)
    );

endmodule

>>> verif/squoct_lattice_distance_tb.sv
// squoct_lattice_distance_tb: self-checking bench for the toric / squoct lattice distance block.
// A directed table of point pairs runs first, then random pairs over several register settings.
// Depends on sqoct_pkg and squoct_lattice_distance.
module squoct_lattice_distance_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 6;
    localparam int PIPE_LATENCY = 8;
    localparam int WDOG_LIMIT   = 4000;
    localparam int PHASE_PAIRS  = 215;
    localparam int N_ROWS       = 18;

    typedef logic [sqoct_pkg::COORD_BITS-1:0] t_pt;
    typedef logic [sqoct_pkg::OUT_BITS-1:0]   t_dist;

    typedef struct packed {
        t_pt   x1;
        t_pt   y1;
        t_pt   x2;
        t_pt   y2;
        logic  typed;
        t_dist want;
    } t_pair_row;

    // rows with typed=1 carry a distance read straight off the lattice at reset settings
    // (squoct, Z syndromes, 96 x 96, i.e. a 32 x 32 virtual lattice)
    localparam t_pair_row PAIR_TAB [N_ROWS] = '{
        '{10'd1,    10'd1,    10'd1,    10'd1,    1'b1, 11'd0},  // identical
        '{10'd0,    10'd0,    10'd0,    10'd0,    1'b1, 11'd0},  // identical at zero
        '{10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1, 11'd0},  // identical at max
        '{10'd1,    10'd1,    10'd7,    10'd1,    1'b1, 11'd2},  // two octagons
        '{10'd94,   10'd94,   10'd1,    10'd1,    1'b1, 11'd2},  // wrap on both axes
        '{10'd1,    10'd1,    10'd4,    10'd1,    1'b0, 11'd0},  // one square end
        '{10'd4,    10'd1,    10'd1,    10'd4,    1'b0, 11'd0},  // two square ends
        '{10'd4,    10'd1,    10'd4,    10'd4,    1'b0, 11'd0},
        '{10'd1,    10'd4,    10'd94,   10'd4,    1'b0, 11'd0},  // square end, wrap on x
        '{10'd0,    10'd0,    10'd1023, 10'd1023, 1'b0, 11'd0},  // beyond the period
        '{10'd1023, 10'd0,    10'd0,    10'd1023, 1'b0, 11'd0},
        '{10'd0,    10'd1,    10'd1,    10'd0,    1'b0, 11'd0},  // same virtual, not same
        '{10'd2,    10'd3,    10'd1,    10'd1,    1'b0, 11'd0},  // not of form 3k+1
        '{10'd1021, 10'd1021, 10'd1,    10'd1,    1'b0, 11'd0},  // outside the lattice
        '{10'd682,  10'd1,    10'd685,  10'd4,    1'b0, 11'd0},
        '{10'h155,  10'h2AA,  10'h2AA,  10'h155,  1'b0, 11'd0},
        '{10'd1,    10'd94,   10'd94,   10'd1,    1'b0, 11'd0},
        '{10'd4,    10'd7,    10'd7,    10'd4,    1'b0, 11'd0}
    };

    logic                             i_clk      = 1'b0;
    logic                             i_rst_n    = 1'b0;
    logic                             psel       = 1'b0;
    logic                             penable    = 1'b0;
    logic                             pwrite     = 1'b0;
    logic [sqoct_pkg::ADDR_BITS-1:0]  paddr      = '0;
    logic [sqoct_pkg::DATA_BITS-1:0]  pwdata     = '0;
    logic [sqoct_pkg::DATA_BITS-1:0]  prdata;
    logic                             pready;
    logic                             start      = 1'b0;
    logic                             busy;
    t_pt                              i_first_x  = '0;
    t_pt                              i_first_y  = '0;
    t_pt                              i_second_x = '0;
    t_pt                              i_second_y = '0;
    logic                             o_valid;
    t_dist                            o_distance;

    // typed distance travels with the beat that carries its pair
    logic                  row_typed  = 1'b0;
    t_dist                 row_dist   = '0;

    sqoct_pkg::t_cfg reg_shadow;
    t_dist  pending_dist [$];
    t_dist  want_dist;
    int     mismatch_cnt = 0;
    int     pairs_sent   = 0;
    int     dist_seen    = 0;
    int     settings_run = 0;
    int     idle_pct     = 0;
    int     quiet_cycles = 0;

    squoct_lattice_distance u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .i_first_x  (i_first_x),
        .i_first_y  (i_first_y),
        .i_second_x (i_second_x),
        .i_second_y (i_second_y),
        .o_valid    (o_valid),
        .o_distance (o_distance)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // ---------------- distance predictor ----------------

    function automatic int unsigned axis_span(int unsigned a, int unsigned b, int unsigned size);
        int unsigned d;
        d = (a > b) ? a - b : b - a;
        if (d <= size && size - d < d) return size - d;
        return d;
    endfunction

    function automatic int unsigned virt_coord(int unsigned c);
        return (c == 0) ? 0 : (c - 1) / 3;
    endfunction

    function automatic int unsigned wrap_up(int unsigned v, int unsigned size);
        return (size == 0) ? 0 : (v + 1) % size;
    endfunction

    function automatic int unsigned wrap_down(int unsigned v, int unsigned size);
        if (v != 0) return v - 1;
        return (size == 0) ? 0 : size - 1;
    endfunction

    // i = 0 picks the up neighbour, i = 1 the down one; octagon sites stay put
    function automatic int unsigned site_x(logic xkind, int unsigned x, int unsigned y,
                                           int unsigned sx, int i);
        if ((x[0] != y[0]) && (x[0] != xkind))
            return (i == 0) ? wrap_up(x, sx) : wrap_down(x, sx);
        return x;
    endfunction

    function automatic int unsigned site_y(logic xkind, int unsigned x, int unsigned y,
                                           int unsigned sy, int i);
        if ((x[0] != y[0]) && (x[0] == xkind))
            return (i == 0) ? wrap_up(y, sy) : wrap_down(y, sy);
        return y;
    endfunction

    function automatic t_dist lattice_distance(sqoct_pkg::t_cfg c,
                                               int unsigned x1, int unsigned y1,
                                               int unsigned x2, int unsigned y2);
        int unsigned sx, sy, na, nb, best, d;
        if (c.lattice_kind)
            return t_dist'(axis_span(x1, x2, c.lattice_width)
                         + axis_span(y1, y2, c.lattice_height));
        if (x1 == x2 && y1 == y2) return '0;
        x1 = virt_coord(x1);
        y1 = virt_coord(y1);
        x2 = virt_coord(x2);
        y2 = virt_coord(y2);
        sx = c.lattice_width / 3;
        sy = c.lattice_height / 3;
        na = (x1[0] != y1[0]) ? 2 : 1;
        nb = (x2[0] != y2[0]) ? 2 : 1;
        best = '1;
        for (int i = 0; i < na; i++)
            for (int j = 0; j < nb; j++) begin
                d = axis_span(site_x(c.syndrome_kind, x1, y1, sx, i),
                              site_x(c.syndrome_kind, x2, y2, sx, j), sx)
                  + axis_span(site_y(c.syndrome_kind, x1, y1, sy, i),
                              site_y(c.syndrome_kind, x2, y2, sy, j), sy);
                if (d < best) best = d;
            end
        return t_dist'(best + na - 1 + nb - 1);
    endfunction

    // ---------------- shadow registers, expectations, checking ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reg_shadow = '{1'b0, 1'b0, sqoct_pkg::SIZE_RESET, sqoct_pkg::SIZE_RESET};
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (sqoct_pkg::t_reg_idx'(paddr[3:2]))
                    sqoct_pkg::REG_LATTICE_KIND:
                        reg_shadow.lattice_kind   = pwdata[0];
                    sqoct_pkg::REG_SYNDROME_KIND:
                        reg_shadow.syndrome_kind  = pwdata[0];
                    sqoct_pkg::REG_LATTICE_WIDTH:
                        reg_shadow.lattice_width  = pwdata[sqoct_pkg::SIZE_BITS-1:0];
                    sqoct_pkg::REG_LATTICE_HEIGHT:
                        reg_shadow.lattice_height = pwdata[sqoct_pkg::SIZE_BITS-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                pending_dist.push_back(row_typed ? row_dist :
                    lattice_distance(reg_shadow, i_first_x, i_first_y, i_second_x, i_second_y));
            if (o_valid === 1'b1) begin
                dist_seen++;
                if (pending_dist.size() == 0) begin
                    $display("%0t: unexpected distance beat: expected none, got %0d",
                             $time, o_distance);
                    mismatch_cnt++;
                end else begin
                    want_dist = pending_dist.pop_front();
                    if (o_distance !== want_dist) begin
                        $display("%0t: distance mismatch: expected %0d, got %0d",
                                 $time, want_dist, o_distance);
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    // watchdog: cycles with no beat on either side or on the register port
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid === 1'b1 || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("%0t: timeout, %0d distances outstanding", $time, pending_dist.size());
            $display("FAIL squoct_lattice_distance");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    task automatic send_pair(input t_pt x1, input t_pt y1, input t_pt x2, input t_pt y2,
                             input logic typed, input t_dist want);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_first_x  <= x1;
        i_first_y  <= y1;
        i_second_x <= x2;
        i_second_y <= y2;
        row_typed  <= typed;
        row_dist   <= want;
        do @(posedge i_clk); while (busy !== 1'b0);
        pairs_sent++;
    endtask

    task automatic drain_pipe();
        start <= 1'b0;
        while (pending_dist.size() != 0) @(posedge i_clk);
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
    endtask

    // write a register, then read it back
    task automatic write_reg(input sqoct_pkg::t_reg_idx idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= sqoct_pkg::ADDR_BITS'({idx, 2'b00});
        pwdata  <= sqoct_pkg::DATA_BITS'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== sqoct_pkg::DATA_BITS'(value)) begin
            $display("%0t: readback of %s: expected %0d, got %0d",
                     $time, idx.name(), value, prdata);
            mismatch_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_lattice(input logic kind, input logic xkind,
                               input int unsigned w, input int unsigned h);
        write_reg(sqoct_pkg::REG_LATTICE_KIND, kind);
        write_reg(sqoct_pkg::REG_SYNDROME_KIND, xkind);
        write_reg(sqoct_pkg::REG_LATTICE_WIDTH, w);
        write_reg(sqoct_pkg::REG_LATTICE_HEIGHT, h);
        settings_run++;
    endtask

    // squoct points are mostly 3k+1 inside the lattice; one in ten is any 10-bit value
    function automatic t_pt rand_coord(logic squoct, int unsigned size);
        int unsigned kmax;
        if ($urandom_range(9) == 0) return t_pt'($urandom_range(1023));
        if (!squoct) return t_pt'($urandom_range(size - 1));
        kmax = size / 3;
        return t_pt'(3 * $urandom_range((kmax == 0) ? 0 : kmax - 1) + 1);
    endfunction

    function automatic t_pt near_coord(logic squoct, t_pt c);
        int step;
        step = squoct ? 3 : 1;
        return t_pt'(int'(c) + step * int'($urandom_range(4)) - 2 * step);
    endfunction

    task automatic random_pairs(input logic squoct, input int unsigned w, input int unsigned h);
        t_pt x1, y1, x2, y2;
        int  pick;
        for (int n = 0; n < PHASE_PAIRS; n++) begin
            x1 = rand_coord(squoct, w);
            y1 = rand_coord(squoct, h);
            pick = $urandom_range(7);
            if (pick == 0) begin
                x2 = x1;
                y2 = y1;
            end else if (pick <= 2) begin
                x2 = near_coord(squoct, x1);
                y2 = near_coord(squoct, y1);
            end else begin
                x2 = rand_coord(squoct, w);
                y2 = rand_coord(squoct, h);
            end
            send_pair(x1, y1, x2, y2, 1'b0, '0);
        end
    endtask

    initial begin
        logic        kind, xkind;
        int unsigned w, h;
        int          directed;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table at reset settings, then again as toric distances
        for (int r = 0; r < N_ROWS; r++)
            send_pair(PAIR_TAB[r].x1, PAIR_TAB[r].y1, PAIR_TAB[r].x2, PAIR_TAB[r].y2,
                      PAIR_TAB[r].typed, PAIR_TAB[r].want);
        drain_pipe();
        set_lattice(1'b1, 1'b0, 96, 96);
        for (int r = 0; r < N_ROWS; r++)
            send_pair(PAIR_TAB[r].x1, PAIR_TAB[r].y1, PAIR_TAB[r].x2, PAIR_TAB[r].y2,
                      1'b0, '0);
        directed = pairs_sent;

        for (int ph = 0; ph < 8; ph++) begin
            drain_pipe();
            case (ph)
                0: begin kind = 1'b0; xkind = 1'b0; w = 96;   h = 96;   end
                1: begin kind = 1'b0; xkind = 1'b1; w = 1023; h = 1023; end
                2: begin kind = 1'b1; xkind = 1'b0; w = 1023; h = 2;    end
                // width below 3: virtual width collapses to zero
                3: begin kind = 1'b0; xkind = 1'b1; w = 2;    h = 5;    end
                4: begin kind = 1'b1; xkind = 1'b1; w = 2;    h = 1023; end
                default: begin
                    kind  = (ph == 6);
                    xkind = (ph == 7);
                    w     = $urandom_range(1023, 2);
                    h     = $urandom_range(1023, 2);
                end
            endcase
            set_lattice(kind, xkind, w, h);
            idle_pct = (ph % 4 == 1) ? 57 : (ph % 4 == 3) ? 36 : 0;
            random_pairs(!kind, w, h);
        end

        idle_pct = 0;
        drain_pipe();

        if (pending_dist.size() != 0) begin
            $display("%0t: %0d distances never arrived", $time, pending_dist.size());
            mismatch_cnt++;
        end
        $display("covered %0d point pairs (%0d directed) over %0d lattice settings,",
                 pairs_sent, directed, settings_run + 1);
        $display("%0d distances checked, %0d mismatches", dist_seen, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("PASS squoct_lattice_distance");
        else
            $display("FAIL squoct_lattice_distance");
        $finish;
    end

endmodule

>>> squoct_lattice_distance.f
src/sqoct_pkg.sv
src/sqoct_cfg.sv
src/sqoct_prep.sv
src/sqoct_wrap.sv
src/sqoct_dist.sv
src/squoct_lattice_distance.sv
verif/squoct_lattice_distance_tb.sv
